### hw/rtl/sprc_pkg.sv
// Shared types, constants and helper functions for the sprite collision core.
// Used by sprc_ctrl, sprc_datapath and sprite_pixel_collision_core.

package sprc_pkg;

    localparam int MAX_SPRITE_DIM = 64;
    localparam int PIXEL_BITS     = 32;

    localparam int STORE_DEPTH  = 4096;
    localparam int ADDR_BITS    = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_DIM_W    = 7;
    localparam int KEY_W        = 32;
    localparam int RECT_W       = 64;
    localparam int RECT_FIELD_W = 16;
    localparam int REQ_W        = 2;

    // Coordinates hold a signed 16-bit origin plus an unsigned 16-bit extent.
    localparam int CW = 20;

    localparam int DIM_BITS = $clog2(MAX_SPRITE_DIM + 1);
    localparam int LC_BITS  = (MAX_SPRITE_DIM > 1) ? $clog2(MAX_SPRITE_DIM) : 1;
    localparam int IDX_BITS = LC_BITS + DIM_BITS;

    // Per axis: the low edge, the span of sprite one, the span of sprite two,
    // and the first coordinates past each sprite.
    localparam int NSEG     = 5;
    localparam int SEG_BITS = $clog2(NSEG);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TWO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE_EN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO_EN   = 3'd7;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_ONE = 2'd0,
        REQ_LOAD_TWO = 2'd1,
        REQ_QUERY    = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP_A,
        ST_PREP_B,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_one;
        logic load_two;
        logic query_latch;
        logic prep_a;
        logic prep_b;
        logic scan_step;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last;
        logic hit;
    } t_dp_status;

    function automatic t_coord cmax(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_coord cmin(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [DIM_BITS-1:0] sat_dim(input logic [CFG_DIM_W-1:0] v);
        if (int'(v) > MAX_SPRITE_DIM) begin
            return DIM_BITS'(MAX_SPRITE_DIM);
        end
        return DIM_BITS'(v);
    endfunction

    // Origin on one axis of a packed rectangle: x for axis 0, y for axis 1.
    function automatic t_coord rect_pos(input logic [RECT_W-1:0] v, input logic axis);
        logic signed [RECT_FIELD_W-1:0] p;
        p = axis ? v[2*RECT_FIELD_W-1:RECT_FIELD_W] : v[RECT_FIELD_W-1:0];
        return t_coord'(p);
    endfunction

    // Extent on one axis of a packed rectangle: width for axis 0, height for axis 1.
    function automatic t_coord rect_len(input logic [RECT_W-1:0] v, input logic axis);
        logic [RECT_FIELD_W-1:0] l;
        l = axis ? v[4*RECT_FIELD_W-1:3*RECT_FIELD_W] : v[3*RECT_FIELD_W-1:2*RECT_FIELD_W];
        return t_coord'(l);
    endfunction

endpackage

### hw/rtl/sprc_ctrl.sv
// Controller state machine of the sprite collision core.
// Depends on sprc_pkg for the state, request and command/status types.

module sprc_ctrl
    import sprc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [REQ_W-1:0]     i_req_type,
    input  t_dp_status           i_status,
    output t_dp_cmd              o_cmd,
    output logic                 busy,
    output logic                 o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_req_type == REQ_QUERY)) begin
                    n_state = ST_PREP_A;
                end
            end
            ST_PREP_A: begin
                n_state = ST_PREP_B;
            end
            ST_PREP_B: begin
                n_state = i_status.empty ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    n_state = ST_DONE;
                end else if (i_status.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    case (i_req_type)
                        REQ_LOAD_ONE: o_cmd.load_one    = 1'b1;
                        REQ_LOAD_TWO: o_cmd.load_two    = 1'b1;
                        REQ_QUERY:    o_cmd.query_latch = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_PREP_A: begin
                o_cmd.prep_a = 1'b1;
            end
            ST_PREP_B: begin
                o_cmd.prep_b = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = !i_status.hit;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/sprc_datapath.sv
// Datapath of the sprite collision core: configuration registers, the two
// pixel stores, the per-axis point walkers and the opacity compare pipeline.
// Depends on sprc_pkg.

module sprc_datapath
    import sprc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [ADDR_BITS-1:0]     i_pixel_addr,
    input  logic [31:0]              i_pixel_value,
    input  logic [RECT_W-1:0]        i_screen_rect_one,
    input  logic [RECT_W-1:0]        i_source_rect_one,
    input  logic [RECT_W-1:0]        i_screen_rect_two,
    input  logic [RECT_W-1:0]        i_source_rect_two,
    output logic                     o_collided
);

    // Configuration registers.
    logic [CFG_DIM_W-1:0] r_width_one;
    logic [CFG_DIM_W-1:0] r_height_one;
    logic [CFG_DIM_W-1:0] r_width_two;
    logic [CFG_DIM_W-1:0] r_height_two;
    logic [KEY_W-1:0]     r_key_one;
    logic [KEY_W-1:0]     r_key_two;
    logic                 r_key_one_en;
    logic                 r_key_two_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_one  <= '0;
            r_height_one <= '0;
            r_width_two  <= '0;
            r_height_two <= '0;
            r_key_one    <= '0;
            r_key_two    <= '0;
            r_key_one_en <= 1'b0;
            r_key_two_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH_ONE:  r_width_one  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT_ONE: r_height_one <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_WIDTH_TWO:  r_width_two  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT_TWO: r_height_two <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_KEY_ONE:    r_key_one    <= i_cfg_data[KEY_W-1:0];
                CFG_KEY_TWO:    r_key_two    <= i_cfg_data[KEY_W-1:0];
                CFG_KEY_ONE_EN: r_key_one_en <= i_cfg_data[0];
                CFG_KEY_TWO_EN: r_key_two_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [DIM_BITS-1:0] dim_one [2];
    logic [DIM_BITS-1:0] dim_two [2];

    assign dim_one[0] = sat_dim(r_width_one);
    assign dim_one[1] = sat_dim(r_height_one);
    assign dim_two[0] = sat_dim(r_width_two);
    assign dim_two[1] = sat_dim(r_height_two);

    // Query rectangles, captured when the query item is accepted.
    logic [RECT_W-1:0] r_scr_one;
    logic [RECT_W-1:0] r_src_one;
    logic [RECT_W-1:0] r_scr_two;
    logic [RECT_W-1:0] r_src_two;

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_latch) begin
            r_scr_one <= i_screen_rect_one;
            r_src_one <= i_source_rect_one;
            r_scr_two <= i_screen_rect_two;
            r_src_two <= i_source_rect_two;
        end
    end

    // Per-axis bounds (index 0 is x, index 1 is y). The sprite spans are
    // given in screen coordinates: [r_oa, r_ea) and [r_ob, r_eb).
    t_coord              r_lo    [2];
    t_coord              r_hi    [2];
    t_coord              r_oa    [2];
    t_coord              r_ea    [2];
    t_coord              r_ob    [2];
    t_coord              r_eb    [2];
    t_coord              r_start [2][NSEG];
    t_coord              r_last  [2][NSEG];
    logic [NSEG-1:0]     r_sval  [2];
    t_coord              r_pos   [2];
    logic [SEG_BITS-1:0] r_seg   [2];
    logic [1:0]          axis_end;

    // Points outside both sprites on an axis all read zero for both, so each
    // axis walks the two sprite spans plus one representative of every gap.
    for (genvar g = 0; g < 2; g++) begin : g_axis
        localparam logic AX = 1'(g);

        logic                at_last;
        logic                has_next;
        logic [SEG_BITS-1:0] nxt_seg;
        logic                step_en;

        always_comb begin
            at_last  = (r_pos[g] == r_last[g][r_seg[g]]);
            has_next = 1'b0;
            nxt_seg  = '0;
            for (int s = NSEG - 1; s >= 0; s--) begin
                if ((SEG_BITS'(s) > r_seg[g]) && r_sval[g][s]) begin
                    has_next = 1'b1;
                    nxt_seg  = SEG_BITS'(s);
                end
            end
        end

        assign axis_end[g] = at_last && !has_next;
        assign step_en     = (g == 0) ? i_cmd.scan_step : (i_cmd.scan_step && axis_end[0]);

        always_ff @(posedge i_clk) begin
            if (i_cmd.prep_a) begin
                r_lo[g] <= cmax(rect_pos(r_scr_one, AX), rect_pos(r_scr_two, AX));
                r_hi[g] <= cmin(
                    cmin(rect_pos(r_scr_one, AX) + rect_len(r_scr_one, AX),
                         rect_pos(r_scr_two, AX) + rect_len(r_scr_two, AX)),
                    cmin(rect_pos(r_scr_one, AX) + rect_len(r_src_one, AX),
                         rect_pos(r_scr_two, AX) + rect_len(r_src_two, AX)));
                r_oa[g] <= rect_pos(r_scr_one, AX) - rect_pos(r_src_one, AX);
                r_ea[g] <= rect_pos(r_scr_one, AX) - rect_pos(r_src_one, AX)
                           + t_coord'(dim_one[g]);
                r_ob[g] <= rect_pos(r_scr_two, AX) - rect_pos(r_src_two, AX);
                r_eb[g] <= rect_pos(r_scr_two, AX) - rect_pos(r_src_two, AX)
                           + t_coord'(dim_two[g]);
            end else if (i_cmd.prep_b) begin
                r_start[g][0] <= r_lo[g];
                r_last[g][0]  <= r_lo[g];
                r_sval[g][0]  <= 1'b1;

                r_start[g][1] <= cmax(r_lo[g], r_oa[g]);
                r_last[g][1]  <= cmin(r_hi[g], r_ea[g]) - t_coord'(1);
                r_sval[g][1]  <= (r_oa[g] < r_hi[g]) && (r_lo[g] < r_ea[g])
                                 && (r_oa[g] < r_ea[g]);

                r_start[g][2] <= cmax(r_lo[g], r_ob[g]);
                r_last[g][2]  <= cmin(r_hi[g], r_eb[g]) - t_coord'(1);
                r_sval[g][2]  <= (r_ob[g] < r_hi[g]) && (r_lo[g] < r_eb[g])
                                 && (r_ob[g] < r_eb[g]);

                r_start[g][3] <= r_ea[g];
                r_last[g][3]  <= r_ea[g];
                r_sval[g][3]  <= (r_lo[g] <= r_ea[g]) && (r_ea[g] < r_hi[g]);

                r_start[g][4] <= r_eb[g];
                r_last[g][4]  <= r_eb[g];
                r_sval[g][4]  <= (r_lo[g] <= r_eb[g]) && (r_eb[g] < r_hi[g]);

                r_pos[g] <= r_lo[g];
                r_seg[g] <= '0;
            end else if (step_en) begin
                if (!at_last) begin
                    r_pos[g] <= r_pos[g] + t_coord'(1);
                end else if (has_next) begin
                    r_pos[g] <= r_start[g][nxt_seg];
                    r_seg[g] <= nxt_seg;
                end else begin
                    r_pos[g] <= r_lo[g];
                    r_seg[g] <= '0;
                end
            end
        end
    end

    // Current point mapped into each sprite.
    t_coord                dx_one;
    t_coord                dy_one;
    t_coord                dx_two;
    t_coord                dy_two;
    logic                  in_one;
    logic                  in_two;
    logic [IDX_BITS-1:0]   idx_one;
    logic [IDX_BITS-1:0]   idx_two;
    logic                  ok_one;
    logic                  ok_two;
    logic [ADDR_BITS-1:0]  rd_addr_one;
    logic [ADDR_BITS-1:0]  rd_addr_two;

    assign dx_one = r_pos[0] - r_oa[0];
    assign dy_one = r_pos[1] - r_oa[1];
    assign dx_two = r_pos[0] - r_ob[0];
    assign dy_two = r_pos[1] - r_ob[1];

    assign in_one = (r_pos[0] >= r_oa[0]) && (r_pos[0] < r_ea[0])
                    && (r_pos[1] >= r_oa[1]) && (r_pos[1] < r_ea[1]);
    assign in_two = (r_pos[0] >= r_ob[0]) && (r_pos[0] < r_eb[0])
                    && (r_pos[1] >= r_ob[1]) && (r_pos[1] < r_eb[1]);

    assign idx_one = IDX_BITS'(dy_one[LC_BITS-1:0]) * IDX_BITS'(dim_one[0])
                     + IDX_BITS'(dx_one[LC_BITS-1:0]);
    assign idx_two = IDX_BITS'(dy_two[LC_BITS-1:0]) * IDX_BITS'(dim_two[0])
                     + IDX_BITS'(dx_two[LC_BITS-1:0]);

    assign ok_one = in_one && (int'(idx_one) < STORE_DEPTH);
    assign ok_two = in_two && (int'(idx_two) < STORE_DEPTH);

    assign rd_addr_one = ADDR_BITS'(idx_one);
    assign rd_addr_two = ADDR_BITS'(idx_two);

    // Pixel stores: one write port for loads, one registered read for the scan.
    logic [PIXEL_BITS-1:0] mem_one [STORE_DEPTH];
    logic [PIXEL_BITS-1:0] mem_two [STORE_DEPTH];
    logic [PIXEL_BITS-1:0] r_pix_one;
    logic [PIXEL_BITS-1:0] r_pix_two;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_one) begin
            mem_one[i_pixel_addr] <= i_pixel_value[PIXEL_BITS-1:0];
        end
        r_pix_one <= mem_one[rd_addr_one];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_two) begin
            mem_two[i_pixel_addr] <= i_pixel_value[PIXEL_BITS-1:0];
        end
        r_pix_two <= mem_two[rd_addr_two];
    end

    // Compare stage, working on the walker's point in the cycle after it is presented.
    logic                  r_in_one;
    logic                  r_in_two;
    logic                  r_pv;
    logic                  r_hit;
    logic [PIXEL_BITS-1:0] pix_one;
    logic [PIXEL_BITS-1:0] pix_two;
    logic                  opq_one;
    logic                  opq_two;

    always_ff @(posedge i_clk) begin
        r_in_one <= ok_one;
        r_in_two <= ok_two;
    end

    assign pix_one = r_in_one ? r_pix_one : '0;
    assign pix_two = r_in_two ? r_pix_two : '0;
    assign opq_one = !r_key_one_en || (pix_one != r_key_one[PIXEL_BITS-1:0]);
    assign opq_two = !r_key_two_en || (pix_two != r_key_two[PIXEL_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_pv <= i_cmd.scan_step;
            if (i_cmd.query_latch) begin
                r_hit <= 1'b0;
            end else if (r_pv && opq_one && opq_two) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_comb begin
        o_status.empty = !((r_lo[0] < r_hi[0]) && (r_lo[1] < r_hi[1]));
        o_status.last  = axis_end[0] && axis_end[1];
        o_status.hit   = r_hit;
    end

    assign o_collided = r_hit;

endmodule

### hw/rtl/sprite_pixel_collision_core.sv
// Top level of the pixel-exact sprite collision core.
// Depends on sprc_pkg, sprc_ctrl and sprc_datapath.
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ------------------------------------------
//   request   start / busy            i_req_type, i_pixel_addr, i_pixel_value,
//                                     i_screen_rect_*, i_source_rect_*
//   result    o_done (one cycle)      o_collided
//   config    i_cfg_we                i_cfg_idx, i_cfg_data
//
// A pixel load is written in the cycle it is accepted and busy stays low. In a
// query each axis walks both sprite spans clipped to the overlap plus up to
// three gap points (at most 2 * 64 + 3 points per axis); the scan visits one
// point pair per cycle through one read port of each pixel store and stops
// shortly after the first opaque pair. An empty overlap skips the scan. Reset
// clears the controller and the configuration registers; the pixel stores are
// not cleared. The result strobe cannot be stalled.

module sprite_pixel_collision_core
    import sprc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic [ADDR_BITS-1:0]   i_pixel_addr,
    input  logic [31:0]            i_pixel_value,
    input  logic [RECT_W-1:0]      i_screen_rect_one,
    input  logic [RECT_W-1:0]      i_source_rect_one,
    input  logic [RECT_W-1:0]      i_screen_rect_two,
    input  logic [RECT_W-1:0]      i_source_rect_two,
    output logic                   o_done,
    output logic                   o_collided,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sprc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .busy       (busy),
        .o_done     (o_done)
    );

    sprc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_pixel_addr      (i_pixel_addr),
        .i_pixel_value     (i_pixel_value),
        .i_screen_rect_one (i_screen_rect_one),
        .i_source_rect_one (i_source_rect_one),
        .i_screen_rect_two (i_screen_rect_two),
        .i_source_rect_two (i_source_rect_two),
        .o_collided        (o_collided)
    );

`ifndef NO_ASSERTIONS
    // After a result the core is ready for the next item.
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("core still busy after a result");

    // A load or an unused request finishes in the cycle it is accepted.
    a_load_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type != REQ_QUERY)) |=> !busy)
        else $error("non-query item made the core busy");

    // An accepted query keeps the core busy and cannot answer at once.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_QUERY)) |=> (busy && !o_done))
        else $error("query did not start a scan");

    // The datapath only walks points while no hit is pending.
    a_no_step_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.scan_step |-> !dp_status.hit)
        else $error("scan stepped after a collision was found");
`endif

endmodule
